/* design/rrsp_pkg.sv */
// Shared constants, types and codes of the record stream parser.
// Used by every module of the parser; depends on nothing else.
package rrsp_pkg;

    localparam int unsigned BASE_W     = 42;
    localparam int unsigned REC_BYTES  = 22;
    localparam int unsigned HDR_BYTES  = 7;
    localparam int unsigned FIFO_DEPTH = 16;
    localparam int unsigned FMUL_LAT   = 4;
    localparam int unsigned TOK_STAGES = FMUL_LAT + 1;

    // Byte positions inside one record.
    localparam logic [4:0] POS_GROUP    = 5'd2;
    localparam logic [4:0] POS_TICK     = 5'd3;
    localparam logic [4:0] POS_TICK_END = 5'd6;
    localparam logic [4:0] POS_CR       = 5'd7;
    localparam logic [4:0] POS_DR       = 5'd11;
    localparam logic [4:0] POS_CE       = 5'd15;
    localparam logic [4:0] POS_DE       = 5'd17;

    // Timestamp divider: the quotient by 1000 is formed as (x >> 3) / 125, one hex digit a step.
    localparam int unsigned DIV_DIGITS = 10;
    localparam int unsigned DV_W       = 4 * DIV_DIGITS;
    localparam logic [43:0] NEG_BIAS   = 44'd616 + 44'd1000 * 44'h200_0000;
    localparam logic [63:0] WRAP_Q     = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000;
    localparam logic [31:0] NEG_TS_ADJ = WRAP_Q[31:0] - 32'h0200_0000;

    // 10000.0 = 625 * 2^4.
    localparam logic [9:0] DOSE_SIG = 10'd625;

    typedef enum logic [1:0] {
        FC_NUM,
        FC_ZERO,
        FC_INF,
        FC_NAN
    } t_fcls;

    typedef struct packed {
        logic        rd_v;
        logic        mk_v;
        logic [31:0] cr;
        logic [31:0] dr;
        logic [15:0] ce;
        logic [15:0] de;
        logic [31:0] ts;
    } t_tok;

endpackage

/* design/rrsp_tdiv.sv */
// Timestamp unit: forms base + 10 * tick offset with 64-bit wrap and divides it by 1000,
// one hex quotient digit per cycle. Depends on rrsp_pkg.
module rrsp_tdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrsp_pkg::BASE_W-1:0] i_base,
    input  logic [31:0]                i_tick,
    output logic [31:0]                o_quo,
    output logic                       o_neg
);
    import rrsp_pkg::*;

    logic        r_go;
    logic [3:0]  r_cnt;
    logic [DV_W-1:0] r_dv;
    logic [6:0]  r_rem;
    logic [31:0] r_quo;
    logic        r_neg;

    logic [43:0] off_ext;
    logic [43:0] sum;
    logic [43:0] biased;
    logic        neg;
    logic [10:0] x;
    logic [3:0]  dig;
    logic [10:0] rem;

    always_comb begin
        off_ext = {{12{i_tick[31]}}, i_tick};
        sum     = {{(44 - BASE_W){1'b0}}, i_base} + (off_ext << 3) + (off_ext << 1);
        neg     = sum[43];
        // A negative sum wraps to 2^64 + sum; the bias keeps the dividend positive.
        biased  = sum + (neg ? NEG_BIAS : 44'd0);
    end

    always_comb begin
        x   = {r_rem, r_dv[DV_W-1 -: 4]};
        dig = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (x >= 11'(125 * k)) begin
                dig = 4'(k);
            end
        end
        rem = x - 11'(dig) * 11'd125;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go  <= 1'b0;
            r_cnt <= 4'd0;
        end else begin
            r_go <= i_start;
            if (r_go) begin
                r_cnt <= 4'(DIV_DIGITS);
            end else if (r_cnt != 4'd0) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_dv  <= biased[DV_W+2:3];
            r_rem <= 7'd0;
            r_quo <= 32'd0;
            r_neg <= neg;
        end else if (r_cnt != 4'd0) begin
            r_dv  <= {r_dv[DV_W-5:0], 4'd0};
            r_rem <= rem[6:0];
            r_quo <= {r_quo[27:0], dig};
        end
    end

    assign o_quo = r_quo;
    assign o_neg = r_neg;

endmodule

/* design/rrsp_fmul.sv */
// Four-stage single-precision multiply by 10000 with round to nearest even.
// Depends on rrsp_pkg.
module rrsp_fmul (
    input  logic        i_clk,
    input  logic [31:0] i_bits,
    output logic [31:0] o_bits
);
    import rrsp_pkg::*;

    logic        r1_sign, r2_sign, r3_sign;
    t_fcls       r1_cls, r2_cls, r3_cls;
    logic [31:0] r1_raw, r2_raw, r3_raw;
    logic [7:0]  r1_eeff, r2_eeff;
    logic [33:0] r1_p, r2_p, r3_p;
    logic [5:0]  r2_l;
    logic [33:0] r3_pn;
    logic signed [9:0] r3_er;
    logic [31:0] r4_out;

    logic [7:0]  exp_in;
    logic [22:0] frac_in;
    t_fcls       cls;
    logic [23:0] m;
    logic [5:0]  lz;
    logic [22:0] mant;
    logic        rnd_up;
    logic [23:0] m24;
    logic signed [9:0] e_fin;
    logic [31:0] packed_out;

    always_comb begin
        exp_in  = i_bits[30:23];
        frac_in = i_bits[22:0];
        if (exp_in == 8'hFF) begin
            cls = (frac_in != 23'd0) ? FC_NAN : FC_INF;
        end else if (exp_in == 8'd0 && frac_in == 23'd0) begin
            cls = FC_ZERO;
        end else begin
            cls = FC_NUM;
        end
        m = {(exp_in != 8'd0), frac_in};
    end

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 34; i++) begin
            if (r1_p[i]) begin
                lz = 6'(i);
            end
        end
    end

    always_comb begin
        mant   = r3_pn[32:10];
        rnd_up = r3_pn[9] & ((|r3_pn[8:0]) | mant[0]);
        m24    = {1'b0, mant} + 24'(rnd_up);
        e_fin  = r3_er + 10'(m24[23]);
        case (r3_cls)
            FC_NAN:  packed_out = r3_raw | 32'h0040_0000;
            FC_INF:  packed_out = {r3_sign, 8'hFF, 23'd0};
            FC_ZERO: packed_out = {r3_sign, 31'd0};
            default: begin
                if (r3_er < 10'sd1) begin
                    // Tiny inputs give an exact subnormal result.
                    packed_out = {r3_sign, 8'd0, r3_p[18:0], 4'd0};
                end else if (e_fin > 10'sd254) begin
                    packed_out = {r3_sign, 8'hFF, 23'd0};
                end else begin
                    packed_out = {r3_sign, e_fin[7:0], m24[22:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r1_sign <= i_bits[31];
        r1_cls  <= cls;
        r1_raw  <= i_bits;
        r1_eeff <= (exp_in == 8'd0) ? 8'd1 : exp_in;
        r1_p    <= 34'(m) * 34'(DOSE_SIG);

        r2_sign <= r1_sign;
        r2_cls  <= r1_cls;
        r2_raw  <= r1_raw;
        r2_eeff <= r1_eeff;
        r2_p    <= r1_p;
        r2_l    <= lz;

        r3_sign <= r2_sign;
        r3_cls  <= r2_cls;
        r3_raw  <= r2_raw;
        r3_p    <= r2_p;
        r3_pn   <= r2_p << (6'd33 - r2_l);
        r3_er   <= $signed({4'd0, r2_l}) + $signed({2'd0, r2_eeff}) - 10'sd19;

        r4_out  <= packed_out;
    end

    assign o_bits = r4_out;

endmodule

/* design/realtime_record_stream_parser_unit.sv */
// Top level of the record stream parser: byte parser, result pipeline and output queue.
// Depends on rrsp_pkg, rrsp_tdiv and rrsp_fmul.
//
// Usage: payload bytes enter on the input channel (i_valid / o_stall), one byte per item,
// with i_last_byte set on the final byte of a buffer. Results leave on the output channel
// (o_valid / i_stall). A complete 22-byte group-0 record gives one reading; the last byte
// of a buffer adds an end marker after any reading that byte completes.
// One byte is taken per cycle while o_stall is low. A result follows the byte that causes
// it: the capture register loads at the edge that accepts that byte, then the four-stage
// float multiplier and the queue write follow. The timestamp divider starts once the tick
// offset is complete and finishes well inside a record.
// Results wait in a 16-entry queue; o_stall rises when 11 or more entries are held, so
// a stalled receiver holds back input only after the queue has filled that far.
// The user must write the base time register with i_cfg_we only while the block is idle;
// the block does not enforce this. Reset clears the parser position, the discard flag,
// the pipeline and the queue, and sets the base time to zero.
module realtime_record_stream_parser_unit #(
    parameter int unsigned FIFO_DEPTH = rrsp_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrsp_pkg::BASE_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_result_kind,
    output logic [31:0]                 o_count_rate_bits,
    output logic [31:0]                 o_dose_rate_bits,
    output logic [15:0]                 o_count_rate_error,
    output logic [15:0]                 o_dose_rate_error,
    output logic [31:0]                 o_timestamp_sec
);
    import rrsp_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    localparam logic [AW:0] STALL_AT = (AW + 1)'(FIFO_DEPTH - TOK_STAGES - 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);

    logic [BASE_W-1:0] r_base;
    logic [4:0]  r_pos, n_pos;
    logic        r_disc, n_disc;
    logic [7:0]  r_group, n_group;
    logic [31:0] r_tick, n_tick;
    logic [31:0] r_cr, n_cr;
    logic [31:0] r_dr, n_dr;
    logic [15:0] r_ce, n_ce;
    logic [15:0] r_de, n_de;

    logic        accept;
    logic        rd, mk, start;
    logic [4:0]  p, p1;
    logic [31:0] quo;
    logic        quo_neg;

    t_tok        r_tok [TOK_STAGES];
    logic [TOK_STAGES-1:0] r_tv;
    t_tok        n_tok;
    t_tok        push_tok;
    logic [31:0] dose_scaled;

    t_tok        r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic        r_sub;
    t_tok        head;
    logic        show_rd, push, pop_out, fifo_pop;

    assign accept  = i_valid & ~o_stall;
    assign o_stall = (r_cnt > STALL_AT);

    always_comb begin
        n_pos   = r_pos;
        n_disc  = r_disc;
        n_group = r_group;
        n_tick  = r_tick;
        n_cr    = r_cr;
        n_dr    = r_dr;
        n_ce    = r_ce;
        n_de    = r_de;
        rd      = 1'b0;
        mk      = 1'b0;
        start   = 1'b0;
        p       = (r_pos >= 5'(REC_BYTES)) ? 5'd0 : r_pos;
        p1      = p + 5'd1;
        if (!r_disc) begin
            case (p) inside
                POS_GROUP: n_group = i_data_byte;
                [5'd3:5'd6]: n_tick[8 * (2'(p - POS_TICK)) +: 8] = i_data_byte;
                [5'd7:5'd10]: n_cr[8 * (2'(p - POS_CR)) +: 8] = i_data_byte;
                [5'd11:5'd14]: n_dr[8 * (2'(p - POS_DR)) +: 8] = i_data_byte;
                [5'd15:5'd16]: n_ce[8 * (1'(p - POS_CE)) +: 8] = i_data_byte;
                [5'd17:5'd18]: n_de[8 * (1'(p - POS_DE)) +: 8] = i_data_byte;
                default: ;
            endcase
            start = (p == POS_TICK_END);
            if (p1 == 5'(HDR_BYTES) && r_group != 8'd0) begin
                n_disc = 1'b1;
                n_pos  = 5'd0;
            end else if (p1 == 5'(REC_BYTES)) begin
                rd    = 1'b1;
                n_pos = 5'd0;
            end else begin
                n_pos = p1;
            end
        end
        if (i_last_byte) begin
            mk     = 1'b1;
            n_pos  = 5'd0;
            n_disc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pos   <= 5'd0;
            r_disc  <= 1'b0;
            r_group <= 8'd0;
            r_tick  <= 32'd0;
            r_cr    <= 32'd0;
            r_dr    <= 32'd0;
            r_ce    <= 16'd0;
            r_de    <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (accept) begin
                r_pos   <= n_pos;
                r_disc  <= n_disc;
                r_group <= n_group;
                r_tick  <= n_tick;
                r_cr    <= n_cr;
                r_dr    <= n_dr;
                r_ce    <= n_ce;
                r_de    <= n_de;
            end
        end
    end

    rrsp_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept & start),
        .i_base  (r_base),
        .i_tick  (r_tick),
        .o_quo   (quo),
        .o_neg   (quo_neg)
    );

    always_comb begin
        n_tok.rd_v = rd;
        n_tok.mk_v = mk;
        n_tok.cr   = r_cr;
        n_tok.dr   = r_dr;
        n_tok.ce   = r_ce;
        n_tok.de   = r_de;
        n_tok.ts   = quo + (quo_neg ? NEG_TS_ADJ : 32'd0);
    end

    // Each item with a result travels alongside the multiplier, then enters the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else begin
            r_tv <= {r_tv[TOK_STAGES-2:0], accept & (rd | mk)};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok[0] <= n_tok;
        for (int k = 1; k < TOK_STAGES; k++) begin
            r_tok[k] <= r_tok[k-1];
        end
    end

    rrsp_fmul u_fmul (
        .i_clk  (i_clk),
        .i_bits (r_tok[0].dr),
        .o_bits (dose_scaled)
    );

    always_comb begin
        push_tok    = r_tok[TOK_STAGES-1];
        push_tok.dr = dose_scaled;
    end

    assign push     = r_tv[TOK_STAGES-1];
    assign head     = r_mem[r_rp];
    assign o_valid  = (r_cnt != '0);
    assign show_rd  = head.rd_v & ~r_sub;
    assign pop_out  = o_valid & ~i_stall;
    // A queue entry holding both a reading and a marker is sent in two items.
    assign fifo_pop = pop_out & (~show_rd | ~head.mk_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (fifo_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW + 1)'(push) - (AW + 1)'(fifo_pop);
            if (pop_out) begin
                r_sub <= ~fifo_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= push_tok;
        end
    end

    assign o_result_kind      = ~show_rd;
    assign o_count_rate_bits  = show_rd ? head.cr : 32'd0;
    assign o_dose_rate_bits   = show_rd ? head.dr : 32'd0;
    assign o_count_rate_error = show_rd ? head.ce : 16'd0;
    assign o_dose_rate_error  = show_rd ? head.de : 16'd0;
    assign o_timestamp_sec    = show_rd ? head.ts : 32'd0;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !fifo_pop |-> r_cnt < (AW + 1)'(FIFO_DEPTH))
        else $error("push into full queue");

    a_disc_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> r_pos == 5'd0)
        else $error("discarding with nonzero position");

    a_sub_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> o_valid && head.rd_v && head.mk_v)
        else $error("split entry without reading and marker");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 5'(REC_BYTES))
        else $error("byte position out of range");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for realtime_record_stream_parser_unit.
// Drives payload bytes, predicts readings and end markers, and checks results; needs rrsp_pkg.
module tb_top;

    import rrsp_pkg::*;

    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_END     = 1'b1;
    localparam int   RANDOM_BYTES = 640;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct {
        logic        kind;
        logic [31:0] cr;
        logic [31:0] dr;
        logic [15:0] ce;
        logic [15:0] de;
        logic [31:0] ts;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [BASE_W-1:0]   i_cfg_wdata;
    logic                i_valid;
    logic                o_stall;
    logic [7:0]          i_data_byte;
    logic                i_last_byte;
    logic                o_valid;
    logic                i_stall;
    logic                o_result_kind;
    logic [31:0]         o_count_rate_bits;
    logic [31:0]         o_dose_rate_bits;
    logic [15:0]         o_count_rate_error;
    logic [15:0]         o_dose_rate_error;
    logic [31:0]         o_timestamp_sec;

    realtime_record_stream_parser_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result_kind     (o_result_kind),
        .o_count_rate_bits (o_count_rate_bits),
        .o_dose_rate_bits  (o_dose_rate_bits),
        .o_count_rate_error(o_count_rate_error),
        .o_dose_rate_error (o_dose_rate_error),
        .o_timestamp_sec   (o_timestamp_sec)
    );

    // Pending bytes, expected results and the predictor's copy of the parser state.
    t_byte_item  byte_q[$];
    t_result     results_due[$];
    logic [7:0]  frame[$];

    logic [BASE_W-1:0] pm_base;
    logic [4:0]        pm_pos;
    logic              pm_skip;
    logic [7:0]        pm_group;
    logic [31:0]       pm_tick;
    logic [31:0]       pm_cr;
    logic [31:0]       pm_dr;
    logic [15:0]       pm_ce;
    logic [15:0]       pm_de;

    int  n_errors    = 0;
    int  n_bytes     = 0;
    int  n_readings  = 0;
    int  n_markers   = 0;
    bit  idle_on     = 1'b1;
    bit  hold_go     = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_left   = 0;
    int  stall_left  = 0;
    int  gap_left    = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Multiply single-precision bits by 10000, round to nearest even.
    function automatic logic [31:0] dose_x10k(input logic [31:0] b);
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] r;
        int          k;
        int          e2;
        int          sh;
        int          eb;
        ex = b[30:23];
        fr = b[22:0];
        if (ex == 8'hFF) begin
            return (fr != 0) ? (b | 32'h0040_0000) : b;
        end
        if (ex == 8'd0 && fr == 23'd0) begin
            return {b[31], 31'd0};
        end
        if (ex == 8'd0) begin
            prod = 64'(fr) * 64'd10000;
            e2 = -149;
        end else begin
            prod = 64'({1'b1, fr}) * 64'd10000;
            e2 = int'(ex) - 150;
        end
        k = 63;
        while (!prod[k]) k--;
        if (k + e2 >= -126) begin
            sh = k - 23;
            eb = k + e2 + 126;
        end else begin
            sh = -149 - e2;
            eb = 0;
        end
        q = prod >> sh;
        rem = prod & ((64'd1 << sh) - 64'd1);
        half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
        if (sh > 0 && (rem > half || (rem == half && q[0]))) q++;
        // The hidden bit of q carries into the exponent field, which covers mantissa overflow.
        r = (64'(eb) << 23) + q;
        if (r >= 64'h7F80_0000) r = 64'h7F80_0000;
        return {b[31], r[30:0]};
    endfunction

    function automatic logic [31:0] stamp_seconds(input logic [BASE_W-1:0] base,
                                                  input logic [31:0] tick);
        logic [63:0] ms;
        logic [63:0] sec;
        ms = 64'(base) + {{32{tick[31]}}, tick} * 64'd10;
        sec = ms / 64'd1000;
        return sec[31:0];
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        t_result   res;
        logic [4:0] p;
        if (!pm_skip) begin
            p = (pm_pos >= REC_BYTES) ? 5'd0 : pm_pos;
            if (p == POS_GROUP) pm_group = b;
            else if (p >= POS_TICK && p <= POS_TICK_END) pm_tick[8*(p-POS_TICK) +: 8] = b;
            else if (p >= POS_CR && p < POS_DR) pm_cr[8*(p-POS_CR) +: 8] = b;
            else if (p >= POS_DR && p < POS_CE) pm_dr[8*(p-POS_DR) +: 8] = b;
            else if (p >= POS_CE && p < POS_DE) pm_ce[8*(p-POS_CE) +: 8] = b;
            else if (p >= POS_DE && p < POS_DE + 2) pm_de[8*(p-POS_DE) +: 8] = b;
            p++;
            if (p == HDR_BYTES && pm_group != 8'd0) begin
                pm_skip = 1'b1;
                p = 5'd0;
            end else if (p == REC_BYTES) begin
                res.kind = KIND_READING;
                res.cr = pm_cr;
                res.dr = dose_x10k(pm_dr);
                res.ce = pm_ce;
                res.de = pm_de;
                res.ts = stamp_seconds(pm_base, pm_tick);
                results_due = {results_due, res};
                p = 5'd0;
            end
            pm_pos = p;
        end
        if (last) begin
            res = '{KIND_END, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0};
            results_due = {results_due, res};
            pm_pos = 5'd0;
            pm_skip = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Byte driver.
    always @(posedge i_clk) begin : driver
        t_byte_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'd0;
            i_last_byte <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data_byte, i_last_byte);
                n_bytes++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    it = byte_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= it.data;
                    i_last_byte <= it.last;
                    if (idle_on && $urandom_range(0, 6) == 0) gap_left <= $urandom_range(1, 7);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, including one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                report("unexpected result kind", 32'(o_result_kind), 32'd0);
            end else begin
                want = results_due.pop_front();
                if (want.kind == KIND_END) n_markers++;
                else n_readings++;
                if (o_result_kind !== want.kind)
                    report("result_kind", 32'(o_result_kind), 32'(want.kind));
                if (o_count_rate_bits !== want.cr)
                    report("count_rate_bits", o_count_rate_bits, want.cr);
                if (o_dose_rate_bits !== want.dr)
                    report("dose_rate_bits", o_dose_rate_bits, want.dr);
                if (o_count_rate_error !== want.ce)
                    report("count_rate_error", 32'(o_count_rate_error), 32'(want.ce));
                if (o_dose_rate_error !== want.de)
                    report("dose_rate_error", 32'(o_dose_rate_error), 32'(want.de));
                if (o_timestamp_sec !== want.ts)
                    report("timestamp_sec", o_timestamp_sec, want.ts);
            end
        end
    end

    task automatic push_record(input logic [7:0] grp, input logic [31:0] tick,
                               input logic [31:0] cr, input logic [31:0] dr,
                               input logic [15:0] ce, input logic [15:0] de);
        frame = {frame, 8'($urandom)};
        frame = {frame, 8'($urandom)};
        frame = {frame, grp};
        for (int i = 0; i < 4; i++) frame = {frame, tick[8*i +: 8]};
        if (grp != 8'd0) return;
        for (int i = 0; i < 4; i++) frame = {frame, cr[8*i +: 8]};
        for (int i = 0; i < 4; i++) frame = {frame, dr[8*i +: 8]};
        frame = {frame, ce[7:0]};
        frame = {frame, ce[15:8]};
        frame = {frame, de[7:0]};
        frame = {frame, de[15:8]};
        for (int i = 0; i < 3; i++) frame = {frame, 8'($urandom)};
    endtask

    task automatic flush_frame();
        t_byte_item it;
        if (frame.size() == 0) frame = {frame, 8'($urandom)};
        while (frame.size() > 0) begin
            it.data = frame.pop_front();
            it.last = (frame.size() == 0);
            byte_q = {byte_q, it};
        end
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 9))
            0: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            1: return {1'($urandom), 8'hFF, 23'd0};
            2: return {1'($urandom), 8'h00, 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(236, 254)), 23'($urandom)};
            4: return {1'($urandom), 31'd0};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_buffer();
        int nrec;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 30)) frame = {frame, 8'($urandom)};
        end else begin
            nrec = $urandom_range(0, 3);
            for (int r = 0; r < nrec; r++) begin
                if ($urandom_range(0, 7) == 0) begin
                    push_record(8'($urandom_range(1, 255)), $urandom, 32'd0, 32'd0,
                                16'd0, 16'd0);
                    repeat ($urandom_range(0, 25)) frame = {frame, 8'($urandom)};
                    break;
                end
                push_record(8'd0, $urandom, $urandom, rand_float(), 16'($urandom),
                            16'($urandom));
            end
            // A cut-off record at the end of the buffer yields nothing.
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 21)) frame = {frame, 8'($urandom)};
        end
        flush_frame();
    endtask

    task automatic write_base(input logic [BASE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pm_base = v;
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || i_valid || results_due.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int budget;
        logic [BASE_W-1:0] bases[4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_data_byte = 8'd0;
        i_last_byte = 1'b0;
        i_stall = 1'b0;
        pm_base = '0;
        pm_pos = 5'd0;
        pm_skip = 1'b0;
        pm_group = 8'd0;
        pm_tick = 32'd0;
        pm_cr = 32'd0;
        pm_dr = 32'd0;
        pm_ce = 16'd0;
        pm_de = 16'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, float special values, discard, truncation, tiny buffers.
        write_base('0);
        push_record(8'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 16'hFFFF, 16'h0000);
        push_record(8'd0, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7F7F_FFFF, 16'h0000, 16'hFFFF);
        push_record(8'd0, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h0000_0001, 16'h1234, 16'h8001);
        push_record(8'd0, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 16'h00FF, 16'hFF00);
        push_record(8'd0, 32'h0000_0064, 32'h1234_5678, 32'hFF80_0000, 16'h5A5A, 16'hA5A5);
        push_record(8'd0, 32'hFFFF_FF9C, 32'h4000_0000, 32'hFFC0_0000, 16'h0001, 16'h8000);
        flush_frame();
        push_record(8'd0, 32'd5, 32'd1, 32'h0080_0000, 16'd2, 16'd3);
        push_record(8'hFF, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0);
        repeat (30) frame = {frame, 8'($urandom)};
        flush_frame();
        push_record(8'd0, 32'd7, 32'd9, 32'h3E4C_CCCD, 16'd4, 16'd5);
        repeat (10) frame = {frame, 8'($urandom)};
        flush_frame();
        frame = {frame, 8'h00};
        flush_frame();
        drain();

        bases[0] = 42'h3FF_FFFF_FFFF;
        bases[1] = 42'd4294967295000;
        bases[2] = {10'($urandom), 32'($urandom)};
        bases[3] = '0;
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            if (ph == 3) idle_on = 1'b0;
            budget = byte_q.size() + RANDOM_BYTES / 4;
            while (byte_q.size() < budget) random_buffer();
            if (ph == 1) hold_go = 1'b1;
            drain();
        end

        $display("Covered %0d bytes, %0d readings and %0d end markers over 5 base times.",
                 n_bytes, n_readings, n_markers);
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Run timed out with %0d results outstanding.", results_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
design/rrsp_pkg.sv
design/rrsp_tdiv.sv
design/rrsp_fmul.sv
design/realtime_record_stream_parser_unit.sv
tb/sv/tb_top.sv
